// ===== rtl/pbc_pkg.sv =====
package pbc_pkg;

    localparam int CW = 20;

    typedef enum logic [1:0] {
        CLS_IN  = 2'd0,
        CLS_OUT = 2'd1,
        CLS_ON  = 2'd2
    } cls_t;

    typedef struct packed {
        logic signed [CW-1:0] lon;
        logic signed [CW-1:0] lat;
    } vtx_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLASS,
        ST_DECIDE,
        ST_WALK,
        ST_DIV,
        ST_PUT_X,
        ST_PUT_V,
        ST_NEXT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic signed [40:0]   num;
        logic signed [20:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic signed [41:0]   quo;
    } div_rsp_t;

endpackage

// ===== rtl/polygon_band_clipper.sv =====
// a quad arrives as 4 words, then each of the two band passes classifies its vertices and,
// when the line cuts, walks them, running the iterative divider for each inserted vertex
// throughput: one word per cycle while loading; while emitting, one result word per cycle
// with m_tready high; not ready during clipping and emitting
// aresetn (synchronous, active low) clears the sequencer, load count and band limits
module polygon_band_clipper #(
    parameter int QUAD_VERTS    = 4,
    parameter int MAX_OUT_VERTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // vertex_lon, vertex_lat, band_top, band_bottom
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // clip_lon, clip_lat
    output logic [1:0]  m_tuser,  // is_empty, overflowed
    output logic        m_tlast
);

    localparam int QW = $clog2(QUAD_VERTS);
    localparam int MW = $clog2(MAX_OUT_VERTS);
    localparam int CW = $clog2(MAX_OUT_VERTS + 1);
    localparam int NW = (CW > QW + 1) ? CW : QW + 1;

    pbc_pkg::vtx_t  src_mem [MAX_OUT_VERTS];
    pbc_pkg::vtx_t  dst_mem [MAX_OUT_VERTS];
    pbc_pkg::cls_t  cls_mem [MAX_OUT_VERTS];

    pbc_pkg::state_t state_reg, state_next;
    logic [NW-1:0] load_reg, load_next;
    logic signed [19:0] top_reg, top_next, bot_reg, bot_next;
    logic [CW-1:0] n_reg, n_next, cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] prev_reg, prev_next;
    logic          pass_reg, pass_next;
    logic          anyin_reg, anyin_next, anyout_reg, anyout_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] k_reg, k_next;
    logic signed [19:0] xlon_reg, xlon_next;

    pbc_pkg::div_req_t dreq;
    pbc_pkg::div_rsp_t drsp;

    pbc_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    logic signed [19:0] y;
    logic signed [21:0] dlt;
    pbc_pkg::cls_t      cls_i;
    pbc_pkg::vtx_t      vi, vp, va, vb;
    pbc_pkg::cls_t      ci, cp;
    logic               wr_src, wr_dst, wr_cls, cp_back;
    logic [MW-1:0]      wr_idx;
    pbc_pkg::vtx_t      wr_v;
    logic signed [42:0] sum;
    logic               in_first;

    assign y  = pass_reg ? bot_reg : top_reg;
    assign vi = src_mem[i_reg[MW-1:0]];
    assign vp = src_mem[prev_reg[MW-1:0]];
    assign ci = cls_mem[i_reg[MW-1:0]];
    assign cp = cls_mem[prev_reg[MW-1:0]];
    assign va = (ci == pbc_pkg::CLS_OUT) ? vp : vi;
    assign vb = (ci == pbc_pkg::CLS_OUT) ? vi : vp;
    assign dlt = pass_reg ? 22'(vi.lat) - 22'(y) : 22'(y) - 22'(vi.lat);
    assign cls_i = (dlt > 22'sd1) ? pbc_pkg::CLS_IN :
                   (dlt < -22'sd1) ? pbc_pkg::CLS_OUT : pbc_pkg::CLS_ON;
    assign sum = 43'(va.lon) + 43'(drsp.quo);
    assign in_first = (load_reg == '0) || (load_reg >= NW'(QUAD_VERTS));

    always_comb begin
        state_next  = state_reg;
        load_next   = load_reg;
        top_next    = top_reg;
        bot_next    = bot_reg;
        n_next      = n_reg;
        cnt_next    = cnt_reg;
        i_next      = i_reg;
        prev_next   = prev_reg;
        pass_next   = pass_reg;
        anyin_next  = anyin_reg;
        anyout_next = anyout_reg;
        ovf_next    = ovf_reg;
        k_next      = k_reg;
        xlon_next   = xlon_reg;
        wr_src = 1'b0;
        wr_dst = 1'b0;
        wr_cls = 1'b0;
        cp_back = 1'b0;
        wr_idx = cnt_reg[MW-1:0];
        wr_v   = vi;
        dreq.start = 1'b0;
        dreq.num = 41'((42'(vb.lon) - 42'(va.lon)) * (42'(y) - 42'(va.lat)));
        dreq.den = 21'(vb.lat) - 21'(va.lat);
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            pbc_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    wr_src = 1'b1;
                    wr_idx = in_first ? '0 : MW'(load_reg);
                    wr_v   = {s_tdata[19:0], s_tdata[39:20]};
                    if (in_first) begin
                        top_next  = s_tdata[59:40];
                        bot_next  = s_tdata[79:60];
                        load_next = NW'(1);
                    end else begin
                        load_next = load_reg + NW'(1);
                    end
                    if ((in_first ? NW'(1) : load_reg + NW'(1)) == NW'(QUAD_VERTS)) begin
                        load_next  = '0;
                        n_next     = CW'(QUAD_VERTS);
                        pass_next  = 1'b0;
                        ovf_next   = 1'b0;
                        i_next     = '0;
                        anyin_next = 1'b0;
                        anyout_next = 1'b0;
                        state_next = pbc_pkg::ST_CLASS;
                    end
                end
            end
            pbc_pkg::ST_CLASS: begin
                if (i_reg == n_reg) begin
                    state_next = pbc_pkg::ST_DECIDE;
                end else begin
                    wr_cls = 1'b1;
                    if (cls_i == pbc_pkg::CLS_IN)  anyin_next = 1'b1;
                    if (cls_i == pbc_pkg::CLS_OUT) anyout_next = 1'b1;
                    i_next = i_reg + CW'(1);
                end
            end
            pbc_pkg::ST_DECIDE: begin
                cnt_next   = '0;
                i_next     = '0;
                prev_next  = n_reg - CW'(1);
                state_next = pbc_pkg::ST_WALK;
                if (n_reg == '0 || !anyout_reg) begin
                    cnt_next   = n_reg;
                    state_next = pbc_pkg::ST_NEXT;
                end else if (!anyin_reg) begin
                    n_next     = '0;
                    state_next = pbc_pkg::ST_EMIT;
                    k_next     = '0;
                end
            end
            pbc_pkg::ST_WALK: begin
                if (i_reg == n_reg) begin
                    cp_back    = 1'b1;
                    state_next = pbc_pkg::ST_NEXT;
                end else if ((ci == pbc_pkg::CLS_OUT && cp == pbc_pkg::CLS_IN) ||
                             (ci == pbc_pkg::CLS_IN && cp == pbc_pkg::CLS_OUT)) begin
                    dreq.start = 1'b1;
                    state_next = pbc_pkg::ST_DIV;
                end else begin
                    state_next = pbc_pkg::ST_PUT_V;
                end
            end
            pbc_pkg::ST_DIV: begin
                if (drsp.done) begin
                    if (dreq.den == '0)
                        xlon_next = va.lon;
                    else if (sum < -43'sd524288)
                        xlon_next = -20'sd524288;
                    else if (sum > 43'sd524287)
                        xlon_next = 20'sd524287;
                    else
                        xlon_next = sum[19:0];
                    state_next = pbc_pkg::ST_PUT_X;
                end
            end
            pbc_pkg::ST_PUT_X: begin
                wr_v = {xlon_reg, y};
                if (cnt_reg < CW'(MAX_OUT_VERTS)) begin
                    wr_dst   = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end else begin
                    ovf_next = 1'b1;
                end
                state_next = pbc_pkg::ST_PUT_V;
            end
            pbc_pkg::ST_PUT_V: begin
                if (ci != pbc_pkg::CLS_OUT) begin
                    if (cnt_reg < CW'(MAX_OUT_VERTS)) begin
                        wr_dst   = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                prev_next  = i_reg;
                i_next     = i_reg + CW'(1);
                state_next = pbc_pkg::ST_WALK;
            end
            pbc_pkg::ST_NEXT: begin
                n_next = cnt_reg;
                i_next = '0;
                anyin_next  = 1'b0;
                anyout_next = 1'b0;
                k_next = '0;
                if (pass_reg) begin
                    state_next = pbc_pkg::ST_EMIT;
                end else begin
                    pass_next  = 1'b1;
                    state_next = pbc_pkg::ST_CLASS;
                end
            end
            pbc_pkg::ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    k_next = k_reg + CW'(1);
                    if (n_reg == '0 || k_reg == n_reg - CW'(1))
                        state_next = pbc_pkg::ST_LOAD;
                end
            end
            default: state_next = pbc_pkg::ST_LOAD;
        endcase
    end

    pbc_pkg::vtx_t ov;
    assign ov = src_mem[k_reg[MW-1:0]];
    assign m_tdata = (n_reg == '0) ? '0 : {ov.lat, ov.lon};
    assign m_tlast = (n_reg == '0) || (k_reg == n_reg - CW'(1));
    assign m_tuser = {ovf_reg, n_reg == '0};

    always_ff @(posedge aclk) begin
        if (wr_src) src_mem[wr_idx] <= wr_v;
        if (wr_cls) cls_mem[i_reg[MW-1:0]] <= cls_i;
        if (wr_dst) dst_mem[cnt_reg[MW-1:0]] <= wr_v;
        if (cp_back) begin
            for (int j = 0; j < MAX_OUT_VERTS; j++) src_mem[j] <= dst_mem[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pbc_pkg::ST_LOAD;
            load_reg  <= '0;
            top_reg   <= '0;
            bot_reg   <= '0;
        end else begin
            state_reg <= state_next;
            load_reg  <= load_next;
            top_reg   <= top_next;
            bot_reg   <= bot_next;
        end
        n_reg      <= n_next;
        cnt_reg    <= cnt_next;
        i_reg      <= i_next;
        prev_reg   <= prev_next;
        pass_reg   <= pass_next;
        anyin_reg  <= anyin_next;
        anyout_reg <= anyout_next;
        ovf_reg    <= ovf_next;
        k_reg      <= k_next;
        xlon_reg   <= xlon_next;
    end

endmodule

// ===== rtl/pbc_divider.sv =====
module pbc_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  pbc_pkg::div_req_t req,
    output pbc_pkg::div_rsp_t rsp
);

    logic [41:0] rem_reg, rem_next;
    logic [41:0] dvd_reg, dvd_next;
    logic [41:0] quo_reg, quo_next;
    logic [21:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [41:0] un;
    logic [20:0] ud;
    logic [42:0] trial;
    logic [41:0] shifted;

    always_comb begin
        un = req.num[40] ? 42'(-{req.num[40], req.num}) : 42'({1'b0, req.num});
        ud = req.den[20] ? 21'(-req.den) : req.den;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[40:0], dvd_reg[41]};
        trial     = {1'b0, shifted} - {21'd0, dvs_reg};
        if (req.start) begin
            // (2n + d) / (2d)
            dvd_next  = 42'({un, 1'b0} + {22'd0, ud});
            dvs_next  = {ud, 1'b0};
            neg_next  = req.num[40] ^ req.den[20];
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = 6'd42;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[40:0], 1'b0};
            if (!trial[42]) begin
                rem_next = trial[41:0];
                quo_next = {quo_reg[40:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[40:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? 42'(-quo_reg) : quo_reg;

endmodule

// ===== tb/pbc_checker.sv =====
`timescale 1ns / 100ps

module pbc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          quads_seen,
    output int          words_seen,
    output int          empties_seen,
    output int          overflows_seen
);

    localparam int NQ = 4;
    localparam int NMAX = 16;

    typedef struct packed {
        logic signed [19:0] lon;
        logic signed [19:0] lat;
        logic               last;
        logic               empty;
        logic               ovf;
    } clip_word_t;

    clip_word_t    clip_queue[$];
    pbc_pkg::vtx_t quad[NQ];
    int            loaded;
    logic signed [19:0] top_lat, bot_lat;

    function automatic logic signed [19:0] crossing_lon(
        logic signed [19:0] y, pbc_pkg::vtx_t a, pbc_pkg::vtx_t b);
        longint den, num, un, ud, q, r;
        den = longint'(b.lat) - longint'(a.lat);
        num = (longint'(b.lon) - longint'(a.lon)) * (longint'(y) - longint'(a.lat));
        q = 0;
        if (den != 0) begin
            un = num < 0 ? -num : num;
            ud = den < 0 ? -den : den;
            q = (2 * un + ud) / (2 * ud);
            if ((num < 0) != (den < 0)) q = -q;
        end
        r = longint'(a.lon) + q;
        if (r < -524288) r = -524288;
        if (r > 524287) r = 524287;
        return r[19:0];
    endfunction

    task automatic band_pass(input int n, input pbc_pkg::vtx_t src[NMAX],
                             input logic signed [19:0] y, input bit keep_below,
                             output int cnt, output pbc_pkg::vtx_t dst[NMAX],
                             inout bit ovf);
        pbc_pkg::cls_t cls[NMAX];
        int   npos, nneg, prev;
        longint d;
        pbc_pkg::vtx_t x;
        npos = 0;
        nneg = 0;
        cnt = 0;
        if (n > NMAX) n = NMAX;
        for (int i = 0; i < n; i++) begin
            d = longint'(src[i].lat) - longint'(y);
            if (keep_below) d = -d;
            if (d > 1) begin
                cls[i] = pbc_pkg::CLS_IN;
                npos++;
            end else if (d < -1) begin
                cls[i] = pbc_pkg::CLS_OUT;
                nneg++;
            end else begin
                cls[i] = pbc_pkg::CLS_ON;
            end
        end
        if (nneg == 0) begin
            for (int i = 0; i < n; i++) dst[i] = src[i];
            cnt = n;
            return;
        end
        if (npos == 0) return;
        prev = n - 1;
        for (int i = 0; i < n; i++) begin
            if (cls[i] == pbc_pkg::CLS_OUT) begin
                if (cls[prev] == pbc_pkg::CLS_IN) begin
                    x.lat = y;
                    x.lon = crossing_lon(y, src[prev], src[i]);
                    if (cnt < NMAX) dst[cnt++] = x; else ovf = 1;
                end
            end else begin
                if (cls[i] == pbc_pkg::CLS_IN && cls[prev] == pbc_pkg::CLS_OUT) begin
                    x.lat = y;
                    x.lon = crossing_lon(y, src[i], src[prev]);
                    if (cnt < NMAX) dst[cnt++] = x; else ovf = 1;
                end
                if (cnt < NMAX) dst[cnt++] = src[i]; else ovf = 1;
            end
            prev = i;
        end
    endtask

    task automatic clip_quad();
        pbc_pkg::vtx_t a[NMAX], b[NMAX], c[NMAX];
        int   n1, n2;
        bit   ovf;
        clip_word_t w;
        ovf = 0;
        for (int i = 0; i < NQ; i++) a[i] = quad[i];
        band_pass(NQ, a, top_lat, 1, n1, b, ovf);
        band_pass(n1, b, bot_lat, 0, n2, c, ovf);
        quads_seen++;
        if (ovf) overflows_seen++;
        if (n2 == 0) begin
            empties_seen++;
            w = '{lon: '0, lat: '0, last: 1, empty: 1, ovf: ovf};
            clip_queue.push_back(w);
        end
        for (int k = 0; k < n2; k++) begin
            w = '{lon: c[k].lon, lat: c[k].lat, last: k == n2 - 1, empty: 0, ovf: ovf};
            clip_queue.push_back(w);
        end
    endtask

    always @(posedge aclk) begin
        clip_word_t e;
        if (!aresetn) begin
            loaded = 0;
            top_lat = '0;
            bot_lat = '0;
            fail_count = 0;
            quads_seen = 0;
            words_seen = 0;
            empties_seen = 0;
            overflows_seen = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_seen++;
                if (clip_queue.size() == 0) begin
                    $error("unexpected word lon=%0d lat=%0d", $signed(m_tdata[19:0]),
                           $signed(m_tdata[39:20]));
                    fail_count++;
                end else begin
                    e = clip_queue.pop_front();
                    if (m_tdata[19:0] !== e.lon) begin
                        $error("clip_lon expected %0d got %0d", e.lon, $signed(m_tdata[19:0]));
                        fail_count++;
                    end
                    if (m_tdata[39:20] !== e.lat) begin
                        $error("clip_lat expected %0d got %0d", e.lat,
                               $signed(m_tdata[39:20]));
                        fail_count++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("is_last expected %0d got %0d", e.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser[0] !== e.empty) begin
                        $error("is_empty expected %0d got %0d", e.empty, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== e.ovf) begin
                        $error("overflowed expected %0d got %0d", e.ovf, m_tuser[1]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (loaded == 0) begin
                    top_lat = s_tdata[59:40];
                    bot_lat = s_tdata[79:60];
                end
                quad[loaded].lon = s_tdata[19:0];
                quad[loaded].lat = s_tdata[39:20];
                if (loaded == NQ - 1) begin
                    loaded = 0;
                    clip_quad();
                end else begin
                    loaded = loaded + 1;
                end
            end
        end
        pending = clip_queue.size();
    end

endmodule

// ===== tb/tb_polygon_band_clipper.sv =====
`timescale 1ns / 100ps

module tb_polygon_band_clipper;

    localparam int LIMIT = 2000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count, pending, quads_seen, words_seen, empties_seen, overflows_seen;
    int          cycle_count;
    bit          calm;

    polygon_band_clipper dut (.*);

    pbc_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_tready <= 1;
        end
    end

    task automatic send_vertex(input logic [19:0] lon, lat, top, bot);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tdata  <= {bot, top, lat, lon};
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_quad(input logic [19:0] lo[4], la[4], input logic [19:0] top, bot);
        for (int i = 0; i < 4; i++) send_vertex(lo[i], la[i], top, bot);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        repeat (2) @(posedge aclk);
        wait (pending == 0);
    endtask

    function automatic logic [19:0] near_line(input logic [19:0] y);
        return 20'(int'($signed(y)) + $signed(20'($urandom_range(0, 8))) - 4);
    endfunction

    task automatic random_quad();
        logic [19:0] lo[4], la[4], top, bot;
        int mode;
        mode = $urandom_range(0, 9);
        top = 20'($urandom);
        bot = 20'($urandom);
        if (mode < 7) begin
            top = 20'($urandom_range(0, 200000));
            bot = 20'(-int'($urandom_range(0, 200000)));
        end
        for (int i = 0; i < 4; i++) begin
            lo[i] = 20'($urandom);
            la[i] = 20'($urandom);
            if (mode < 5) la[i] = 20'($urandom_range(0, 600000) - 300000);
            else if (mode == 5) la[i] = near_line($urandom_range(0, 1) ? top : bot);
        end
        send_quad(lo, la, top, bot);
    endtask

    initial begin
        logic [19:0] lo[4], la[4];
        aresetn  = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        calm     = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // fully inside
        lo = '{20'd10, 20'd100, 20'd100, 20'd10};
        la = '{20'd10, 20'd10, 20'd50, 20'd50};
        send_quad(lo, la, 20'd1000, 20'h0_0000 - 20'd1000);
        // fully above, fully below
        la = '{20'd5000, 20'd5000, 20'd6000, 20'd6000};
        send_quad(lo, la, 20'd1000, 20'h0_0000 - 20'd1000);
        la = '{20'hF0000, 20'hF0000, 20'hF1000, 20'hF1000};
        send_quad(lo, la, 20'd1000, 20'h0_0000 - 20'd1000);
        // straddling both lines, extreme coordinates
        lo = '{20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h80000};
        la = '{20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF};
        send_quad(lo, la, 20'd100, 20'hFFF9C);
        // on-boundary vertices within tolerance
        lo = '{20'd0, 20'd300, 20'd300, 20'd0};
        la = '{20'd101, 20'd99, 20'hFFF9D, 20'hFFF9B};
        send_quad(lo, la, 20'd100, 20'hFFF9C);
        // inverted band leaves nothing
        la = '{20'd0, 20'd10, 20'd20, 20'd30};
        send_quad(lo, la, 20'hFFF00, 20'd256);
        // saturating crossing
        lo = '{20'h7FFF0, 20'h80000, 20'h7FFFF, 20'h80010};
        la = '{20'h7FFFF, 20'h80000, 20'h7FFFE, 20'h80001};
        send_quad(lo, la, 20'd3, 20'hFFFFD);

        for (int q = 0; q < 54; q++) random_quad();
        drain();
        repeat (300) @(posedge aclk);
        for (int q = 0; q < 28; q++) random_quad();
        calm = 1;
        for (int q = 0; q < 6; q++) random_quad();

        drain();
        repeat (600) @(posedge aclk);
        $display("covered %0d quads, %0d result words, %0d empty, %0d overflowed",
                 quads_seen, words_seen, empties_seen, overflows_seen);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
